>>> sv/adaptive_motion_level_classifier_defines.svh
// Assertion macros shared by the motion level classifier RTL.
`ifndef ADAPTIVE_MOTION_LEVEL_CLASSIFIER_DEFINES_SVH
`define ADAPTIVE_MOTION_LEVEL_CLASSIFIER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define AMLC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");

// Next-cycle implication, checked out of reset.
`define AMLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

// Invariant that holds at every edge out of reset.
`define AMLC_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("invariant violated");

`else

`define AMLC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define AMLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define AMLC_ASSERT_ALWAYS(lbl, clk, rst_n, cond)

`endif

`endif

>>> sv/amlc_pkg.sv
// Types and constants shared by the motion level classifier modules.
package amlc_pkg;

	// Q8 percentage and ring sum widths.
	localparam int PCT_W = 15;
	localparam int SUM_W = 19;
	localparam int FED_W = 5;
	localparam int CFG_IDX_W = 3;
	localparam int ITER_W = 5;
	localparam int PCT_FULL_N = 25600;

	localparam logic [PCT_W-1:0] PCT_FULL = 15'd25600;
	localparam logic [FED_W-1:0] FED_MAX = 5'd31;

	// Iteration counts of the shared divider.
	localparam logic [ITER_W-1:0] AVG_ITERS = 5'd19;
	localparam logic [ITER_W-1:0] FRAME_ITERS = 5'd15;

	// Register reset values.
	localparam logic [PCT_W-1:0] RST_WARMUP_LO = 15'd512;
	localparam logic [PCT_W-1:0] RST_WARMUP_HI = 15'd7680;
	localparam logic [PCT_W-1:0] RST_LOW_BAND = 15'd2560;
	localparam logic [7:0] RST_CALM_DIFF = 8'd30;
	localparam logic [PCT_W-1:0] RST_LO_FLOOR = 15'd256;
	localparam logic [PCT_W-1:0] RST_HI_CAP = 15'd24320;
	localparam logic [3:0] RST_WARMUP_FRAMES = 4'd3;

	// Request kinds.
	localparam logic ACT_FEED = 1'b0;
	localparam logic ACT_CLASSIFY = 1'b1;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WARMUP_LO,
		CFG_WARMUP_HI,
		CFG_LOW_BAND,
		CFG_CALM_DIFF,
		CFG_LO_FLOOR,
		CFG_HI_CAP,
		CFG_WARMUP_FRAMES
	} cfg_idx_t;

	// Motion levels.
	typedef enum logic [1:0] {
		LVL_NONE,
		LVL_LOW,
		LVL_MEDIUM,
		LVL_HIGH
	} level_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_THRESH,
		S_AVG_WAIT,
		S_FRAME,
		S_FRAME_WAIT,
		S_LEVEL,
		S_OUT
	} state_t;

	// Divider control from the controller.
	typedef struct packed {
		logic start;
		logic frame_mode;
	} div_ctl_t;

	// Divider status back to the controller.
	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

>>> sv/amlc_serial_div.sv
// Restoring divider that retires one quotient bit per cycle.
module amlc_serial_div #(
	parameter int DVW = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  amlc_pkg::div_ctl_t           ctl,
	input  logic [amlc_pkg::SUM_W-1:0]   dividend,
	input  logic [DVW-1:0]               rem_init,
	input  logic [DVW-1:0]               divisor,
	output amlc_pkg::div_sts_t           sts,
	output logic [amlc_pkg::PCT_W-1:0]   quotient
);
	import amlc_pkg::*;

	logic             busy_q;
	logic [ITER_W-1:0] cnt_q;
	logic [DVW-1:0]   rem_q;
	logic [DVW-1:0]   div_q;
	logic [SUM_W-1:0] sh_q;
	logic [PCT_W-1:0] quo_q;

	logic [DVW:0]     rem_sh;
	logic [DVW:0]     rem_sub;
	logic             ge;

	// One trial subtraction on the remainder with the next dividend bit.
	always_comb begin
		rem_sh = {rem_q, sh_q[SUM_W-1]};
		rem_sub = rem_sh - {1'b0, div_q};
		ge = (rem_sh >= {1'b0, div_q});
	end

	// Iteration counter and busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			cnt_q <= ctl.frame_mode ? FRAME_ITERS : AVG_ITERS;
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end else begin
				busy_q <= 1'b0;
			end
		end
	end

	// Remainder, dividend shifter and quotient shifter.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= rem_init;
			div_q <= divisor;
			sh_q <= dividend;
			quo_q <= '0;
		end else if (busy_q && (cnt_q != '0)) begin
			rem_q <= ge ? rem_sub[DVW-1:0] : rem_sh[DVW-1:0];
			sh_q <= {sh_q[SUM_W-2:0], 1'b0};
			quo_q <= {quo_q[PCT_W-2:0], ge};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = busy_q && (cnt_q == '0);
	assign quotient = quo_q;

endmodule

>>> sv/adaptive_motion_level_classifier.sv
// Top level of the adaptive motion level classifier.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+------------------------------------------------
//  item    | item_valid/stall     | action, sample_pct, chg_count, pix_count, diff_avg
//  result  | result_valid/stall   | level, frame_pct, avg_pct, lo_pct, hi_pct, warmup_left
//  cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One request is worked at a time. A feed during warm-up does not use the divider; once
// thresholds adapt, a feed may run the ring mean and a classify may also run the frame share
// on the shared bit-serial divider: 19 iterations for the ring mean, 15 for the frame share.
// Reset clears the control state, the ring position, fill count and sum, and loads the
// register defaults. The ring contents are not cleared; the fill count guards them.
// A finished result waits in the output register while the next request is taken.
`include "adaptive_motion_level_classifier_defines.svh"

module adaptive_motion_level_classifier #(
	parameter int WINDOW = 10,
	parameter int PIXEL_COUNT_BITS = 24
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Item channel.
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic                               action,
	input  logic [amlc_pkg::PCT_W-1:0]         sample_pct,
	input  logic [PIXEL_COUNT_BITS-1:0]        chg_count,
	input  logic [PIXEL_COUNT_BITS-1:0]        pix_count,
	input  logic [7:0]                         diff_avg,
	// Result channel.
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic [1:0]                         level,
	output logic [amlc_pkg::PCT_W-1:0]         frame_pct,
	output logic [amlc_pkg::PCT_W-1:0]         avg_pct,
	output logic [amlc_pkg::PCT_W-1:0]         lo_pct,
	output logic [amlc_pkg::PCT_W-1:0]         hi_pct,
	output logic [3:0]                         warmup_left,
	// Configuration channel.
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [amlc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [15:0]                        cfg_data
);
	import amlc_pkg::*;

	localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int DW = PIXEL_COUNT_BITS + PCT_W;
	localparam logic [FED_W-1:0] WIN_N = FED_W'(WINDOW);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW - 1);
	localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(WINDOW * PCT_FULL_N);

	// Configuration registers.
	logic [PCT_W-1:0] warmup_lo_q, warmup_hi_q, low_band_q, lo_floor_q, hi_cap_q;
	logic [7:0]       calm_diff_q;
	logic [3:0]       warmup_frames_q;

	// Ring of recent samples and its bookkeeping.
	logic [PCT_W-1:0] ring_q [WINDOW];
	logic [POS_W-1:0] pos_q;
	logic [FED_W-1:0] fed_q;
	logic [SUM_W-1:0] sum_q;

	// Captured request and work registers.
	state_t           state_q, state_d;
	logic             act_q;
	logic [PIXEL_COUNT_BITS-1:0] chg_q, tot_q;
	logic [7:0]       md_q;
	logic [PCT_W-1:0] avg_w_q, lo_w_q, hi_w_q, frame_w_q;
	logic [3:0]       left_w_q;
	level_t           level_w_q;

	// Output register.
	logic             res_valid_q;
	logic [1:0]       level_q;
	logic [PCT_W-1:0] frame_q, avg_q, lo_q, hi_q;
	logic [3:0]       left_q;

	// Divider hookup.
	div_ctl_t         div_ctl;
	div_sts_t         div_sts;
	logic [SUM_W-1:0] div_dividend;
	logic [PIXEL_COUNT_BITS-1:0] div_rem_init, div_divisor;
	logic [PCT_W-1:0] div_quo;

	// Control strobes and derived values.
	logic             accept, push_en, warm, thr_warm, thr_adapt;
	logic             frame_zero, frame_full, lvl_en, out_load, out_free;
	logic [FED_W-1:0] fill_n;
	logic [PCT_W-1:0] sample_clamp, a_val, lo_a, hi_a, warm_avg;
	logic [16:0]      a_x3;
	logic [15:0]      warm_sum;
	logic [DW-1:0]    prod;
	logic [SUM_W-1:0] sum_next;

	assign cfg_ready = 1'b1;
	assign accept = item_valid && !item_stall;
	assign out_free = !res_valid_q || !result_stall;

	// Configuration writes; an index beyond the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warmup_lo_q <= RST_WARMUP_LO;
			warmup_hi_q <= RST_WARMUP_HI;
			low_band_q <= RST_LOW_BAND;
			calm_diff_q <= RST_CALM_DIFF;
			lo_floor_q <= RST_LO_FLOOR;
			hi_cap_q <= RST_HI_CAP;
			warmup_frames_q <= RST_WARMUP_FRAMES;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_WARMUP_LO:     warmup_lo_q <= cfg_data[PCT_W-1:0];
				CFG_WARMUP_HI:     warmup_hi_q <= cfg_data[PCT_W-1:0];
				CFG_LOW_BAND:      low_band_q <= cfg_data[PCT_W-1:0];
				CFG_CALM_DIFF:     calm_diff_q <= cfg_data[7:0];
				CFG_LO_FLOOR:      lo_floor_q <= cfg_data[PCT_W-1:0];
				CFG_HI_CAP:        hi_cap_q <= cfg_data[PCT_W-1:0];
				CFG_WARMUP_FRAMES: warmup_frames_q <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	// Ring update values: clamp the sample and retire the oldest once full.
	always_comb begin
		sample_clamp = (sample_pct > PCT_FULL) ? PCT_FULL : sample_pct;
		sum_next = sum_q + SUM_W'(sample_clamp);
		if (fed_q >= WIN_N) begin
			sum_next = sum_next - SUM_W'(ring_q[pos_q]);
		end
	end

	// Threshold derivation from a mean or from the warm-up registers.
	always_comb begin
		warm = (fed_q < {1'b0, warmup_frames_q});
		fill_n = (fed_q < WIN_N) ? fed_q : WIN_N;
		a_val = (state_q == S_AVG_WAIT) ? div_quo : '0;
		lo_a = ({1'b0, a_val[PCT_W-1:1]} < lo_floor_q) ? lo_floor_q : {1'b0, a_val[PCT_W-1:1]};
		a_x3 = {2'b00, a_val} + {1'b0, a_val, 1'b0};
		hi_a = (a_x3[16:1] > {1'b0, hi_cap_q}) ? hi_cap_q : a_x3[PCT_W:1];
		warm_sum = {1'b0, warmup_lo_q} + {1'b0, warmup_hi_q};
		warm_avg = warm_sum[15:1];
	end

	// Frame product changed * 25600 and divider operands.
	always_comb begin
		prod = (DW'(chg_q) << 14) + (DW'(chg_q) << 13) + (DW'(chg_q) << 10);
		if (state_q == S_FRAME) begin
			div_rem_init = prod[DW-1:PCT_W];
			div_dividend = {prod[PCT_W-1:0], {(SUM_W - PCT_W){1'b0}}};
			div_divisor = tot_q;
		end else begin
			div_rem_init = '0;
			div_dividend = sum_q;
			div_divisor = PIXEL_COUNT_BITS'(fill_n);
		end
	end

	// Controller: next state and strobes.
	always_comb begin
		state_d = state_q;
		item_stall = (state_q != S_IDLE);
		push_en = 1'b0;
		thr_warm = 1'b0;
		thr_adapt = 1'b0;
		frame_zero = 1'b0;
		frame_full = 1'b0;
		lvl_en = 1'b0;
		out_load = 1'b0;
		div_ctl = '0;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					push_en = (action == ACT_FEED);
					state_d = S_THRESH;
				end
			end
			S_THRESH: begin
				if (warm) begin
					thr_warm = 1'b1;
					state_d = (act_q == ACT_CLASSIFY) ? S_FRAME : S_OUT;
				end else if (fill_n == '0) begin
					thr_adapt = 1'b1;
					state_d = (act_q == ACT_CLASSIFY) ? S_FRAME : S_OUT;
				end else begin
					div_ctl.start = 1'b1;
					state_d = S_AVG_WAIT;
				end
			end
			S_AVG_WAIT: begin
				if (div_sts.done) begin
					thr_adapt = 1'b1;
					state_d = (act_q == ACT_CLASSIFY) ? S_FRAME : S_OUT;
				end
			end
			S_FRAME: begin
				if (tot_q == '0) begin
					frame_zero = 1'b1;
					state_d = S_OUT;
				end else if (chg_q >= tot_q) begin
					frame_full = 1'b1;
					state_d = S_LEVEL;
				end else begin
					div_ctl.start = 1'b1;
					div_ctl.frame_mode = 1'b1;
					state_d = S_FRAME_WAIT;
				end
			end
			S_FRAME_WAIT: begin
				if (div_sts.done) begin
					state_d = S_LEVEL;
				end
			end
			S_LEVEL: begin
				lvl_en = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State register and ring bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pos_q <= '0;
			fed_q <= '0;
			sum_q <= '0;
		end else begin
			state_q <= state_d;
			if (push_en) begin
				pos_q <= (pos_q == POS_LAST) ? '0 : pos_q + 1'b1;
				sum_q <= sum_next;
				if (fed_q != FED_MAX) begin
					fed_q <= fed_q + 1'b1;
				end
			end
		end
	end

	// Ring storage, written at the current position.
	always_ff @(posedge clk) begin
		if (push_en) begin
			ring_q[pos_q] <= sample_clamp;
		end
	end

	// Captured request fields and work registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= action;
			chg_q <= chg_count;
			tot_q <= pix_count;
			md_q <= diff_avg;
			frame_w_q <= '0;
			level_w_q <= LVL_NONE;
		end
		if (thr_warm) begin
			avg_w_q <= warm_avg;
			lo_w_q <= warmup_lo_q;
			hi_w_q <= warmup_hi_q;
			left_w_q <= warmup_frames_q - fed_q[3:0];
		end
		if (thr_adapt) begin
			avg_w_q <= a_val;
			lo_w_q <= lo_a;
			hi_w_q <= hi_a;
			left_w_q <= '0;
		end
		if (frame_zero) begin
			frame_w_q <= '0;
		end
		if (frame_full) begin
			frame_w_q <= PCT_FULL;
		end
		if ((state_q == S_FRAME_WAIT) && div_sts.done) begin
			frame_w_q <= div_quo;
		end
		// Level decision; the order of the tests matters.
		if (lvl_en) begin
			priority if (frame_w_q < lo_w_q) begin
				level_w_q <= LVL_NONE;
			end else if (frame_w_q < low_band_q) begin
				level_w_q <= (md_q < calm_diff_q) ? LVL_LOW : LVL_MEDIUM;
			end else if (frame_w_q < hi_w_q) begin
				level_w_q <= LVL_MEDIUM;
			end else begin
				level_w_q <= LVL_HIGH;
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			level_q <= level_w_q;
			frame_q <= frame_w_q;
			avg_q <= avg_w_q;
			lo_q <= lo_w_q;
			hi_q <= hi_w_q;
			left_q <= left_w_q;
		end
	end

	assign result_valid = res_valid_q;
	assign level = level_q;
	assign frame_pct = frame_q;
	assign avg_pct = avg_q;
	assign lo_pct = lo_q;
	assign hi_pct = hi_q;
	assign warmup_left = left_q;

	// Shared serial divider for the ring mean and the frame share.
	amlc_serial_div #(
		.DVW(PIXEL_COUNT_BITS)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(div_ctl),
		.dividend(div_dividend),
		.rem_init(div_rem_init),
		.divisor(div_divisor),
		.sts(div_sts),
		.quotient(div_quo)
	);

	// An accepted request always leaves the idle state.
	`AMLC_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, state_q != S_IDLE)
	// The divider is started only from the two launch states and never while busy.
	`AMLC_ASSERT_IMPLY(a_div_start, clk, arst_n, div_ctl.start,
		!div_sts.busy && (state_q == S_THRESH || state_q == S_FRAME))
	// The ring sum never exceeds a full window of full-scale samples.
	`AMLC_ASSERT_ALWAYS(a_sum_bound, clk, arst_n, sum_q <= SUM_MAX)
	// The write position stays inside the ring.
	`AMLC_ASSERT_ALWAYS(a_pos_bound, clk, arst_n, pos_q <= POS_LAST)
	// Loading the output register presents a result next cycle.
	`AMLC_ASSERT_NEXT(a_out_load, clk, arst_n, out_load, result_valid)

endmodule
